// ===== hw/rtl/stfe_pkg.sv =====
package stfe_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int INDEX_BITS      = 17;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
    localparam int QM_BITS         = SINE_TABLE_BITS - 2;
    localparam int QADDR_BITS      = SINE_TABLE_BITS - 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam int MUL_A_BITS = 32;
    localparam int MUL_B_BITS = 17;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    localparam logic [16:0] ENV_ONE = 17'd65536;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_PHASE_STEP  = 3'd0;
    localparam cfg_idx_t CFG_NOTE_LENGTH = 3'd1;
    localparam cfg_idx_t CFG_FADE_LENGTH = 3'd2;
    localparam cfg_idx_t CFG_FADE_STEP   = 3'd3;
    localparam cfg_idx_t CFG_AMPLITUDE   = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ENV  = 5'b00010,
        ST_AMP  = 5'b00100,
        ST_MAG  = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    typedef logic [14:0] qsine_tab_t [0:QUARTER];

    // shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv_calc(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(pi/2 * m / QUARTER) * 32767, integer Taylor series in Q2.30
    function automatic logic [14:0] qsine_calc(input int m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        d;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (HALF_PI_Q30 * 64'(m)) >> QM_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 6; k++)
        begin
            d    = 64'(2 * k) * 64'(2 * k + 1);
            term = udiv_calc((term * x2) >> 30, d);
            if ((k & 1) == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        r = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (r > 64'd32767)
            r = 64'd32767;
        return r[14:0];
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t t;
        for (int m = 0; m <= QUARTER; m++)
        begin
            t[m] = qsine_calc(m);
        end
        return t;
    endfunction

    localparam qsine_tab_t QSINE_TAB = build_qsine();

endpackage

// ===== hw/rtl/stfe_rom.sv =====
module stfe_rom
    import stfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [QADDR_BITS-1:0] addr,
    output logic [14:0]           q
);

    logic [14:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= QSINE_TAB[addr];
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/stfe_mul.sv =====
module stfe_mul
    import stfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [MUL_A_BITS-1:0] a,
    input  logic [MUL_B_BITS-1:0] b,
    output logic [MUL_P_BITS-1:0] p
);

    logic [MUL_P_BITS-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/sine_tone_with_fade_envelope_unit.sv =====
// An accepted input beat runs through ENV, AMP, MAG and WB: three passes
// through the shared multiplier (ramp, amplitude, sine magnitude) and a
// writeback held while the output is blocked; no new beat is taken before it.
// Reset (rst_n low, asynchronous): no note playing, index and phase zero,
// registers at their defaults, output empty.
module sine_tone_with_fade_envelope_unit
    import stfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         restart,
    output logic         out_valid,
    input  logic         out_ready,
    output logic signed [15:0] sample,
    output logic         active,
    output logic         last
);

    logic [31:0] phase_step_reg;
    logic [16:0] note_length_reg;
    logic [11:0] fade_length_reg;
    logic [16:0] fade_step_reg;
    logic [14:0] amplitude_reg;

    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [31:0]           phase_reg, phase_next;
    logic                  note_active_reg, note_active_next;

    state_t state_reg, state_next;

    logic                  play_reg;
    logic                  full_reg;
    logic                  last_ctx_reg;
    logic                  neg_reg;
    logic [16:0]           count_reg;

    logic                  out_valid_reg;
    logic signed [15:0]    sample_reg;
    logic                  act_out_reg;
    logic                  last_out_reg;

    logic                  accept;
    logic                  out_free;
    logic [INDEX_BITS-1:0] cur_i;
    logic [31:0]           cur_phase;
    logic                  cur_act;
    logic                  ended;
    logic                  play;
    logic                  in_fade;
    logic                  out_fade;
    logic                  is_last;
    logic [INDEX_BITS:0]   i_plus1;
    logic [17:0]           i_plus_fade;
    logic [16:0]           count;

    logic [1:0]            quad;
    logic [QM_BITS-1:0]    qm;
    logic [QADDR_BITS-1:0] rom_addr;
    logic [14:0]           rom_q;

    logic                  mul_en;
    logic [MUL_A_BITS-1:0] mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    logic [MUL_P_BITS-1:0] mul_p;
    logic [16:0]           env;
    logic [15:0]           mag;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_WB) && out_free);
    assign accept   = in_valid && in_ready;

    // current item view after restart
    always_comb
    begin
        cur_i       = restart ? '0 : index_reg;
        cur_phase   = restart ? '0 : phase_reg;
        cur_act     = restart || note_active_reg;
        ended       = cur_i >= note_length_reg;
        play        = cur_act && !ended;
        in_fade     = cur_i < INDEX_BITS'(fade_length_reg);
        i_plus_fade = 18'(cur_i) + 18'(fade_length_reg);
        out_fade    = (fade_length_reg != '0) && (i_plus_fade > 18'(note_length_reg));
        count       = out_fade ? (note_length_reg - cur_i) : cur_i;
        i_plus1     = (INDEX_BITS + 1)'(cur_i) + 1'b1;
        is_last     = (i_plus1 >= (INDEX_BITS + 1)'(note_length_reg)) || (&cur_i);

        index_next       = play ? i_plus1[INDEX_BITS-1:0] : cur_i;
        phase_next       = play ? (cur_phase + phase_step_reg) : cur_phase;
        note_active_next = play && !is_last;

        quad     = cur_phase[31:30];
        qm       = cur_phase[29:30-QM_BITS];
        rom_addr = quad[0] ? (QADDR_BITS'(QUARTER) - QADDR_BITS'(qm)) : QADDR_BITS'(qm);
    end

    stfe_rom u_rom (
        .clk  (clk),
        .en   (accept),
        .addr (rom_addr),
        .q    (rom_q)
    );

    always_comb
    begin
        if (full_reg)
            env = ENV_ONE;
        else if (mul_p[33:0] > 34'(ENV_ONE))
            env = ENV_ONE;
        else
            env = mul_p[16:0];
    end

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg) inside
            ST_ENV:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_BITS'(count_reg);
                mul_b  = fade_step_reg;
            end
            ST_AMP:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_BITS'(env);
                mul_b  = MUL_B_BITS'(amplitude_reg);
            end
            ST_MAG:
            begin
                mul_en = 1'b1;
                mul_a  = mul_p[MUL_A_BITS-1:0];
                mul_b  = MUL_B_BITS'(rom_q);
            end
            ST_IDLE, ST_WB:
            begin
                mul_en = 1'b0;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    stfe_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign mag = mul_p[46:31];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_ENV : ST_IDLE;
            ST_ENV:  state_next = ST_AMP;
            ST_AMP:  state_next = ST_MAG;
            ST_MAG:  state_next = ST_WB;
            ST_WB:
            begin
                if (accept)
                    state_next = ST_ENV;
                else if (out_free)
                    state_next = ST_IDLE;
                else
                    state_next = ST_WB;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= 32'd85704563;
            note_length_reg <= 17'd7717;
            fade_length_reg <= 12'd441;
            fade_step_reg   <= 17'd149;
            amplitude_reg   <= 15'd16000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data;
                CFG_NOTE_LENGTH: note_length_reg <= cfg_data[16:0];
                CFG_FADE_LENGTH: fade_length_reg <= cfg_data[11:0];
                CFG_FADE_STEP:   fade_step_reg   <= cfg_data[16:0];
                CFG_AMPLITUDE:   amplitude_reg   <= cfg_data[14:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            index_reg       <= '0;
            phase_reg       <= '0;
            note_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                index_reg       <= index_next;
                phase_reg       <= phase_next;
                note_active_reg <= note_active_next;
            end
            if ((state_reg == ST_WB) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            play_reg     <= play;
            full_reg     <= !(in_fade || out_fade);
            count_reg    <= count;
            last_ctx_reg <= is_last;
            neg_reg      <= quad[1];
        end
        if ((state_reg == ST_WB) && out_free)
        begin
            sample_reg   <= !play_reg ? '0 : (neg_reg ? -signed'(mag) : signed'(mag));
            act_out_reg  <= play_reg;
            last_out_reg <= play_reg && last_ctx_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign active    = act_out_reg;
    assign last      = last_out_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_ENV)
        else $error("accepted beat did not start the sequence");

    a_mag_to_wb: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAG |=> state_reg == ST_WB)
        else $error("multiply sequence broken");

    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !active) |-> (sample == 16'sd0 && !last))
        else $error("inactive beat not silent");

    a_ready_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && state_reg == ST_WB) |-> out_free)
        else $error("input taken while result blocked");
`endif

endmodule
